// ----- rtl/lkvc_pkg.sv -----
// Shared sizes, types and codes for the LRU key/value cache.
package lkvc_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_W      = 5;
    localparam int FAULT_W    = 16;
    localparam int USED_W     = $clog2(DEPTH + 1);

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [FAULT_W-1:0]    t_fault;
    typedef logic [USED_W-1:0]     t_used;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_op;

    // broadcast to every cell for the item being accepted
    typedef struct packed {
        logic move;       // shift younger entries down and load the tail
        logic from_head;  // shift starts at the oldest slot (eviction)
        logic append;     // load the first free slot
    } t_cell_cmd;

endpackage

// ----- rtl/lkvc_cell.sv -----
// One slot of the recency chain: key, value, valid and the neighbour ripple.
module lkvc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkvc_pkg::t_cell_cmd i_cmd,
    input  lkvc_pkg::t_key    i_key,
    input  lkvc_pkg::t_value  i_new_value,
    input  lkvc_pkg::t_key    i_above_key,
    input  lkvc_pkg::t_value  i_above_value,
    input  logic              i_above_valid,
    input  logic              i_below_valid,
    input  logic              i_seen,
    input  lkvc_pkg::t_value  i_rd,
    output logic              o_seen,
    output lkvc_pkg::t_value  o_rd,
    output logic              o_match,
    output lkvc_pkg::t_key    o_key,
    output lkvc_pkg::t_value  o_value,
    output logic              o_valid
);
    import lkvc_pkg::*;

    t_key   r_key;
    t_value r_value;
    logic   r_valid;
    t_key   n_key;
    t_value n_value;
    logic   n_valid;
    logic   w_last;
    logic   w_free;
    logic   w_shift;
    logic   w_load;

    assign o_match = r_valid && (r_key == i_key);
    assign o_seen  = i_seen | o_match;
    assign o_rd    = i_rd | (o_match ? r_value : '0);

    // youngest valid slot, and first empty slot
    assign w_last  = r_valid && !i_above_valid;
    assign w_free  = !r_valid && i_below_valid;

    assign w_shift = i_cmd.move && r_valid && !w_last && (i_cmd.from_head || o_seen);
    assign w_load  = (i_cmd.move && w_last) || (i_cmd.append && w_free);

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        n_valid = r_valid;
        priority if (w_load) begin
            n_key   = i_key;
            n_value = i_new_value;
            n_valid = 1'b1;
        end else if (w_shift) begin
            n_key   = i_above_key;
            n_value = i_above_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache built from a chain of slots.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  request  | i_valid / o_stall         | i_op, i_key, i_value
//  result   | o_valid / i_stall         | o_hit, o_read_value, o_evicted,
//           |                           | o_fault_count, o_entries_used
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_data (capacity)
//
// One item per cycle while o_stall is low: the key is compared in every slot at once
// and the recency shift ripples through the slot chain within the accepting cycle.
// The result is held in the output register from the cycle after acceptance.
// A stalled result holds the request side only while the output register is full.
// Synchronous active-low reset empties all slots, clears the fault count and
// sets capacity to the full depth.
module lru_key_value_cache (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  lkvc_pkg::t_key             i_key,
    input  lkvc_pkg::t_value           i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_hit,
    output lkvc_pkg::t_value           o_read_value,
    output logic                       o_evicted,
    output lkvc_pkg::t_fault           o_fault_count,
    output logic [lkvc_pkg::CAP_W-1:0] o_entries_used,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_data
);
    import lkvc_pkg::*;

    t_used      r_cap;
    t_used      r_used;
    t_fault     r_faults;
    logic       r_out_valid;
    logic       r_hit;
    t_value     r_rd;
    logic       r_evicted;

    t_used      n_cap;
    t_used      n_used;
    t_fault     n_faults;

    logic       w_accept;
    logic       w_hit;
    logic       w_set;
    logic       w_full;
    logic       w_set_miss;
    t_value     w_new_value;
    t_cell_cmd  w_cmd;

    logic [DEPTH:0]   w_seen;
    t_value           w_rd [DEPTH+1];
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_valid;
    t_key             w_key [DEPTH];
    t_value           w_val [DEPTH];

    assign o_stall     = r_out_valid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign w_hit      = w_seen[DEPTH];
    assign w_set      = (t_op'(i_op) == OP_SET);
    assign w_full     = (r_used >= r_cap);
    assign w_set_miss = w_set && !w_hit;

    assign w_cmd.move      = w_accept && (w_hit || (w_set_miss && w_full));
    assign w_cmd.from_head = !w_hit;
    assign w_cmd.append    = w_accept && w_set_miss && !w_full;

    assign w_new_value = (w_hit && !w_set) ? w_rd[DEPTH] : i_value;

    assign w_seen[0] = 1'b0;
    assign w_rd[0]   = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   w_above_valid;
        logic   w_below_valid;
        t_key   w_above_key;
        t_value w_above_value;

        if (g == DEPTH - 1) begin : g_top
            assign w_above_valid = 1'b0;
            assign w_above_key   = '0;
            assign w_above_value = '0;
        end else begin : g_mid
            assign w_above_valid = w_valid[g+1];
            assign w_above_key   = w_key[g+1];
            assign w_above_value = w_val[g+1];
        end

        if (g == 0) begin : g_head
            assign w_below_valid = 1'b1;
        end else begin : g_rest
            assign w_below_valid = w_valid[g-1];
        end

        lkvc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_key         (i_key),
            .i_new_value   (w_new_value),
            .i_above_key   (w_above_key),
            .i_above_value (w_above_value),
            .i_above_valid (w_above_valid),
            .i_below_valid (w_below_valid),
            .i_seen        (w_seen[g]),
            .i_rd          (w_rd[g]),
            .o_seen        (w_seen[g+1]),
            .o_rd          (w_rd[g+1]),
            .o_match       (w_match[g]),
            .o_key         (w_key[g]),
            .o_value       (w_val[g]),
            .o_valid       (w_valid[g])
        );
    end

    // capacity is clamped to 1..DEPTH when written
    always_comb begin
        n_cap = r_cap;
        if (i_cfg_valid && o_cfg_ready) begin
            priority if (i_cfg_data == '0) begin
                n_cap = t_used'(1);
            end else if (i_cfg_data > CAP_W'(DEPTH)) begin
                n_cap = t_used'(DEPTH);
            end else begin
                n_cap = t_used'(i_cfg_data);
            end
        end
    end

    always_comb begin
        n_used   = r_used;
        n_faults = r_faults;
        if (w_cmd.append) begin
            n_used = r_used + t_used'(1);
        end
        if (w_accept && w_set_miss && (r_faults != '1)) begin
            n_faults = r_faults + t_fault'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= t_used'(DEPTH);
            r_used      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap    <= n_cap;
            r_used   <= n_used;
            r_faults <= n_faults;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit     <= w_hit;
            r_rd      <= (w_hit && !w_set) ? w_rd[DEPTH] : '0;
            r_evicted <= w_set_miss && w_full;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_hit;
    assign o_read_value   = r_rd;
    assign o_evicted      = r_evicted;
    assign o_fault_count  = r_faults;
    assign o_entries_used = CAP_W'(r_used);

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= t_used'(DEPTH))
        else $error("entry count beyond depth");

    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_used) && (w_valid >> r_used) == '0)
        else $error("valid slots not a packed prefix of the entry count");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("key stored in more than one slot");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> !o_hit)
        else $error("eviction reported on a hit");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.append |=> r_used == $past(r_used) + t_used'(1))
        else $error("append did not grow the entry count");

endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for the LRU key/value cache: directed rows, then random traffic per capacity.
module testbench;
    import lkvc_pkg::*;

    typedef struct packed {
        logic             hit;
        t_value           rd;
        logic             evicted;
        t_fault           faults;
        logic [CAP_W-1:0] used;
    } t_result;

    typedef struct packed {
        t_op     op;
        t_key    key;
        t_value  val;
        logic    typed;
        t_result want;
    } t_req;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_op              op;
        t_key             key;
        t_value           val;
        logic [CAP_W-1:0] cap;
        logic             typed;
        t_result          want;
    } t_row;

    localparam int NUM_ROWS   = 21;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_LEN  = 190;
    localparam int POOL_LEN   = 24;
    localparam int MAX_SHOWN  = 40;
    localparam int BUF_LEN    = 4096;

    // results typed in where they follow directly from reset and the extremes
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_REQ, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 16'd0, 5'd0}},
        '{ROW_REQ, OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 16'd1, 5'd1}},
        '{ROW_REQ, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 16'd1, 5'd1}},
        '{ROW_REQ, OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 16'd2, 5'd2}},
        '{ROW_REQ, OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 16'd2, 5'd2}},
        '{ROW_REQ, OP_SET, 32'h0000_0000, 32'h1234_5678, 5'd0, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 16'd2, 5'd2}},
        '{ROW_REQ, OP_GET, 32'h0000_0001, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 16'd2, 5'd2}},
        '{ROW_REQ, OP_SET, 32'h8000_0000, 32'hAAAA_AAAA, 5'd0, 1'b0, '0},
        '{ROW_REQ, OP_SET, 32'h7FFF_FFFF, 32'h5555_5555, 5'd0, 1'b0, '0},
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd2, 1'b0, '0},
        '{ROW_REQ, OP_SET, 32'h0000_0005, 32'h0F0F_0F0F, 5'd0, 1'b0, '0},
        '{ROW_REQ, OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b0, '0},
        '{ROW_REQ, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, '0},
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, '0},
        '{ROW_REQ, OP_SET, 32'h0000_0006, 32'hF0F0_F0F0, 5'd0, 1'b0, '0},
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, '0},
        '{ROW_REQ, OP_SET, 32'h0000_0007, 32'hDEAD_BEEF, 5'd0, 1'b0, '0},
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, '0},
        '{ROW_REQ, OP_GET, 32'h0000_0007, 32'h0000_0000, 5'd0, 1'b0, '0},
        '{ROW_REQ, OP_SET, 32'h0000_0008, 32'h0000_0001, 5'd0, 1'b0, '0},
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd16, 1'b0, '0}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    logic             i_op        = 1'b0;
    t_key             i_key       = '0;
    t_value           i_value     = '0;
    logic             o_valid;
    logic             i_stall     = 1'b0;
    logic             o_hit;
    t_value           o_read_value;
    logic             o_evicted;
    t_fault           o_fault_count;
    logic [CAP_W-1:0] o_entries_used;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data  = '0;

    // shadow of the cache, oldest entry in slot 0
    t_key             slot_key [DEPTH];
    t_value           slot_val [DEPTH];
    int               slot_fill    = 0;
    t_fault           miss_cnt     = '0;
    logic [CAP_W-1:0] capacity_reg = 5'd16;

    // requests waiting to be driven and results waiting to be checked, as ring buffers
    t_req    pending_requests [BUF_LEN];
    int      req_wr = 0;
    int      req_rd = 0;
    t_result awaited_lookups  [BUF_LEN];
    int      exp_wr = 0;
    int      exp_rd = 0;
    t_req    cur;
    t_key    key_pool [POOL_LEN];

    int gap_pct    = 9;
    int stall_pct  = 9;
    int hold_left  = 0;
    int errors     = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_hits     = 0;
    int n_evicts   = 0;
    int n_cfg      = 0;

    lru_key_value_cache dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_read_value   (o_read_value),
        .o_evicted      (o_evicted),
        .o_fault_count  (o_fault_count),
        .o_entries_used (o_entries_used),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(12 * 600000);
        $display("timeout at %0t", $time);
        $display("[lru_key_value_cache] ERROR");
        $finish;
    end

    function automatic t_result lru_update(t_op op, t_key key, t_value val);
        t_result r;
        t_value  keep;
        int      lim;
        int      pos;
        int      i;
        r   = '0;
        pos = -1;
        lim = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        for (i = 0; i < slot_fill; i++) begin
            if (pos < 0 && slot_key[i] == key) pos = i;
        end
        if (pos >= 0) begin
            r.hit = 1'b1;
            keep  = (op == OP_GET) ? slot_val[pos] : val;
            if (op == OP_GET) r.rd = keep;
            for (i = pos; i < slot_fill - 1; i++) begin
                slot_key[i] = slot_key[i + 1];
                slot_val[i] = slot_val[i + 1];
            end
            slot_key[slot_fill - 1] = key;
            slot_val[slot_fill - 1] = keep;
        end else if (op == OP_SET) begin
            if (slot_fill >= lim) begin
                for (i = 0; i < slot_fill - 1; i++) begin
                    slot_key[i] = slot_key[i + 1];
                    slot_val[i] = slot_val[i + 1];
                end
                slot_fill--;
                r.evicted = 1'b1;
            end
            slot_key[slot_fill] = key;
            slot_val[slot_fill] = val;
            slot_fill++;
            if (miss_cnt != '1) miss_cnt++;
        end
        r.faults = miss_cnt;
        r.used   = slot_fill[CAP_W-1:0];
        return r;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic add_request(t_req job);
        pending_requests[req_wr % BUF_LEN] = job;
        req_wr++;
    endtask

    // request side
    always @(posedge i_clk) begin : request_side
        t_result r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r = lru_update(cur.op, cur.key, cur.val);
                awaited_lookups[exp_wr % BUF_LEN] = cur.typed ? cur.want : r;
                exp_wr++;
                n_accepted++;
                if (r.hit) n_hits++;
                if (r.evicted) n_evicts++;
            end
            if (!i_valid || !o_stall) begin
                if (req_wr != req_rd && $urandom_range(99) >= gap_pct) begin
                    cur = pending_requests[req_rd % BUF_LEN];
                    req_rd++;
                    i_valid <= 1'b1;
                    i_op    <= cur.op;
                    i_key   <= cur.key;
                    i_value <= cur.val;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin : result_side
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (exp_wr == exp_rd) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%0t: unexpected item, expected none, got hit=%b rd=%h",
                                 $time, o_hit, o_read_value);
                end else begin
                    want = awaited_lookups[exp_rd % BUF_LEN];
                    exp_rd++;
                    n_checked++;
                    check_field("hit", 32'(want.hit), 32'(o_hit));
                    check_field("read_value", want.rd, o_read_value);
                    check_field("evicted", 32'(want.evicted), 32'(o_evicted));
                    check_field("fault_count", 32'(want.faults), 32'(o_fault_count));
                    check_field("entries_used", 32'(want.used), 32'(o_entries_used));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic settle();
        do @(negedge i_clk);
        while (req_wr != req_rd || i_valid || exp_wr != exp_rd);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        settle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        capacity_reg = cap;
        n_cfg++;
    endtask

    // mostly keys from a small pool so hits and recency moves happen, some stray keys
    task automatic queue_mixed(int n, int pool_n);
        t_req job;
        int   sel;
        int   k;
        for (k = 0; k < n; k++) begin
            sel       = $urandom_range(99);
            job       = '0;
            job.op    = $urandom_range(1) ? OP_SET : OP_GET;
            job.key   = (sel < 80) ? key_pool[$urandom_range(pool_n - 1)] : t_key'($urandom);
            job.val   = (sel % 10 == 0) ? '1 : (sel % 10 == 1) ? '0 : t_value'($urandom);
            add_request(job);
        end
    endtask

    initial begin : sequencer
        logic [CAP_W-1:0] phase_cap [NUM_PHASES];
        t_req             job;
        int               k;
        phase_cap = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd9, 5'd2, 5'd16, 5'd12, 5'd3};
        phase_cap[8] = 5'($urandom_range(31));
        for (k = 0; k < POOL_LEN; k++) key_pool[k] = t_key'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        key_pool[5] = key_pool[4] ^ 32'h0000_0001;
        key_pool[7] = key_pool[6] ^ 32'h8000_0000;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NUM_ROWS; k++) begin
            if (DIRECTED_ROWS[k].kind == ROW_CFG) begin
                write_capacity(DIRECTED_ROWS[k].cap);
            end else begin
                job.op    = DIRECTED_ROWS[k].op;
                job.key   = DIRECTED_ROWS[k].key;
                job.val   = DIRECTED_ROWS[k].val;
                job.typed = DIRECTED_ROWS[k].typed;
                job.want  = DIRECTED_ROWS[k].want;
                add_request(job);
            end
        end

        for (k = 0; k < NUM_PHASES; k++) begin
            write_capacity(phase_cap[k]);
            gap_pct   = (k == 3) ? 0 : 9;
            stall_pct = (k == 3) ? 0 : 9;
            queue_mixed(PHASE_LEN, $urandom_range(2, POOL_LEN));
            if (k == 5) begin
                // hold the result side off long enough for the input to back up
                repeat (10) @(negedge i_clk);
                hold_left = 60;
            end
        end

        settle();
        repeat (4) @(negedge i_clk);
        $display("%0d requests checked (%0d hits, %0d evictions) across %0d capacity writes",
                 n_checked, n_hits, n_evicts, n_cfg);
        $display("capacities 0, 1, 16 and 31 exercised; final fault count %0d", miss_cnt);
        if (errors == 0) begin
            $display("[lru_key_value_cache] OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("[lru_key_value_cache] ERROR");
        end
        $finish;
    end

endmodule
